// ----- hw/rtl/bcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int US_PER_MS_DEF  = 1000;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int US_WIDTH       = 32;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLICK_MIN  = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_PRESS = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DOUBLE_GAP = 2'd3;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_WIDTH-1:0] CLICK_MIN_RST  = 16'd50;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] DOUBLE_GAP_RST = 16'd400;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PRESSED = 4'b0010,
    PH_WAIT    = 4'b0100,
    PH_SECOND  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ms;
    logic [CFG_WIDTH-1:0] click_min_ms;
    logic [CFG_WIDTH-1:0] long_press_ms;
    logic [CFG_WIDTH-1:0] double_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic a_load;
    logic b_load;
    logic step;
  } pipe_ctl_t;

endpackage

// ----- hw/rtl/bcc_ms_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_ms_conv
// Input register and microsecond to millisecond conversion by reciprocal
// multiplication, registered.
// ----------------------------------------------------------------------------
module bcc_ms_conv
  import bcc_pkg::*;
#(
  parameter int US_PER_MS  = US_PER_MS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  pipe_ctl_t             ctl,
  input  logic                  level_in,
  input  logic [US_WIDTH-1:0]   time_in,
  output logic                  b_level,
  output logic [TIME_WIDTH-1:0] b_ms
);

  localparam int            SHIFT_L    = $clog2(US_PER_MS);
  localparam int            PROD_SHIFT = US_WIDTH + SHIFT_L;
  localparam int            MUL_W      = US_WIDTH + 1;
  localparam int            PROD_W     = PROD_SHIFT + US_WIDTH;
  localparam logic [63:0]   RECIP      = ((64'd1 << PROD_SHIFT) / US_PER_MS) + 64'd1;

  logic                a_level;
  logic [US_WIDTH-1:0] a_time;
  logic [PROD_W-1:0]   prod;
  logic [US_WIDTH-1:0] quot;

  always_ff @(posedge clk) begin
    if (ctl.a_load) begin
      a_level <= level_in;
      a_time  <= time_in;
    end
  end

  // exact floor division for any US_WIDTH-bit input
  assign prod = PROD_W'(a_time) * PROD_W'(RECIP[MUL_W-1:0]);
  assign quot = prod[PROD_SHIFT +: US_WIDTH];

  always_ff @(posedge clk) begin
    if (ctl.b_load) begin
      b_level <= a_level;
      b_ms    <= TIME_WIDTH'(quot);
    end
  end

endmodule

// ----- hw/rtl/bcc_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_fsm
// Press phase machine, event classification and result register.
// ----------------------------------------------------------------------------
module bcc_fsm
  import bcc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pipe_ctl_t             ctl,
  input  cfg_t                  cfg,
  input  logic                  active,
  input  logic [TIME_WIDTH-1:0] now,
  output logic [1:0]            event_code,
  output logic                  long_held
);

  phase_t                phase, phase_next;
  logic [TIME_WIDTH-1:0] press_start, press_start_next;
  logic [TIME_WIDTH-1:0] release_t, release_t_next;
  logic [TIME_WIDTH-1:0] held, held_next;
  logic                  long_seen, long_seen_next;
  event_t                ev;
  logic [TIME_WIDTH-1:0] since_press;
  logic [TIME_WIDTH-1:0] since_release;

  assign since_press   = now - press_start;
  assign since_release = now - release_t;

  always_comb begin
    phase_next       = phase;
    press_start_next = press_start;
    release_t_next   = release_t;
    held_next        = held;
    long_seen_next   = long_seen;
    ev               = EV_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (active) begin
          phase_next       = PH_PRESSED;
          press_start_next = now;
        end
      end
      PH_PRESSED: begin
        held_next = since_press;
        if (!active && since_press < TIME_WIDTH'(cfg.debounce_ms)) begin
          phase_next = PH_IDLE;
        end else if (!active) begin
          phase_next     = PH_WAIT;
          release_t_next = now;
        end else if (since_press > TIME_WIDTH'(cfg.long_press_ms)) begin
          long_seen_next = 1'b1;
          ev             = EV_LONG;
          phase_next     = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (since_release > TIME_WIDTH'(cfg.double_gap_ms)) begin
          if (held > TIME_WIDTH'(cfg.click_min_ms)) begin
            ev = EV_SINGLE;
          end
          phase_next = PH_IDLE;
        end else if (active) begin
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (!active && since_press > TIME_WIDTH'(cfg.debounce_ms)) begin
          ev             = EV_DOUBLE;
          phase_next     = PH_IDLE;
          release_t_next = now;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      long_seen   <= 1'b0;
      press_start <= '0;
      release_t   <= '0;
      held        <= '0;
    end else if (ctl.step) begin
      phase       <= phase_next;
      long_seen   <= long_seen_next;
      press_start <= press_start_next;
      release_t   <= release_t_next;
      held        <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      event_code <= ev;
      long_held  <= long_seen_next;
    end
  end

endmodule

// ----- hw/rtl/button_click_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Polled push-button classifier: single click, double click, long press.
// ----------------------------------------------------------------------------
//  channel | handshake            | beat
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_stall  | level_active, time_us
//  out     | out_valid / out_stall| event_code, long_held
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One beat per cycle sustained while out_stall is low; a result passes the
//  input register, millisecond multiply and phase update into the result
//  register. The multiply stage sets the critical path.
//  rst is synchronous: clears pipeline valids, phase, sticky flag; resets config.
//  Empty stages keep filling while a result is held under out_stall;
//  in_stall rises only once all three stages are full and out_stall is high.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module button_click_classifier_unit
  import bcc_pkg::*;
#(
  parameter int US_PER_MS  = US_PER_MS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     level_active,
  input  logic [US_WIDTH-1:0]      time_us,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               event_code,
  output logic                     long_held,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data
);

  cfg_t                  cfg;
  pipe_ctl_t             ctl;
  logic                  a_valid;
  logic                  b_valid;
  logic                  out_load;
  logic                  b_level;
  logic [TIME_WIDTH-1:0] b_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= DEBOUNCE_RST;
      cfg.click_min_ms  <= CLICK_MIN_RST;
      cfg.long_press_ms <= LONG_PRESS_RST;
      cfg.double_gap_ms <= DOUBLE_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data;
        CFG_CLICK_MIN:  cfg.click_min_ms  <= cfg_data;
        CFG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        CFG_DOUBLE_GAP: cfg.double_gap_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_load   = !out_valid || !out_stall;
  assign ctl.step   = b_valid && out_load;
  assign ctl.b_load = !b_valid || out_load;
  assign ctl.a_load = !a_valid || ctl.b_load;
  assign in_stall   = !ctl.a_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.a_load) begin
        a_valid <= in_valid;
      end
      if (ctl.b_load) begin
        b_valid <= a_valid;
      end
      if (out_load) begin
        out_valid <= b_valid;
      end
    end
  end

  bcc_ms_conv #(
    .US_PER_MS  (US_PER_MS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_conv (
    .clk      (clk),
    .ctl      (ctl),
    .level_in (level_active),
    .time_in  (time_us),
    .b_level  (b_level),
    .b_ms     (b_ms)
  );

  bcc_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cfg        (cfg),
    .active     (b_level),
    .now        (b_ms),
    .event_code (event_code),
    .long_held  (long_held)
  );

endmodule
